### sv/fractional_rate_event_pacer_top_defines.svh
// Assertion macros for the fractional-rate event pacer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef FRACTIONAL_RATE_EVENT_PACER_TOP_DEFINES_SVH
`define FRACTIONAL_RATE_EVENT_PACER_TOP_DEFINES_SVH

// same-cycle implication
`define FREP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FREP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/frep_pkg.sv
// Shared types and constants for the fractional-rate event pacer.
// No dependencies.
`timescale 1ns / 1ps

package frep_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BASE_W     = 8;
  localparam int SPAWN_W    = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PER_TICK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_EXTRAS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SKIP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_SKIP       = 3'd4;

  typedef struct packed {
    logic [BASE_W-1:0]     base_per_tick;
    logic [CFG_DATA_W-1:0] interval_ticks;
    logic [CFG_DATA_W-1:0] interval_extras;
    logic [CFG_DATA_W-1:0] short_skip;
    logic [CFG_DATA_W-1:0] long_skip;
  } cfg_t;

  typedef struct packed {
    logic [SPAWN_W-1:0] spawn_count;
    logic               extra_spawned;
    logic               interval_restart;
    logic               underspawn_error;
  } res_t;

endpackage

### sv/frep_cfg.sv
// Configuration register file for the pacer.
// Depends on frep_pkg.
`timescale 1ns / 1ps

module frep_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [frep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frep_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output frep_pkg::cfg_t                   cfg
);

  frep_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        frep_pkg::CFG_BASE_PER_TICK:
          cfg_nxt.base_per_tick = cfg_wdata[frep_pkg::BASE_W-1:0];
        frep_pkg::CFG_INTERVAL_TICKS:  cfg_nxt.interval_ticks  = cfg_wdata;
        frep_pkg::CFG_INTERVAL_EXTRAS: cfg_nxt.interval_extras = cfg_wdata;
        frep_pkg::CFG_SHORT_SKIP:      cfg_nxt.short_skip      = cfg_wdata;
        frep_pkg::CFG_LONG_SKIP:       cfg_nxt.long_skip       = cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_per_tick   <= '0;
      cfg_r.interval_ticks  <= frep_pkg::CFG_DATA_W'(1);
      cfg_r.interval_extras <= '0;
      cfg_r.short_skip      <= '0;
      cfg_r.long_skip       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/frep_core.sv
// Pacing counters and per-tick step logic.
// Depends on frep_pkg.
`timescale 1ns / 1ps

module frep_core #(
  parameter int INTERVAL_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  frep_pkg::cfg_t cfg,
  input  logic           step,     // beat leaves the input register
  input  logic           tick,
  output frep_pkg::res_t res
);

  localparam int W = INTERVAL_WIDTH;

  logic [W-1:0] ticks_r, ticks_nxt;
  logic [W-1:0] extras_r, extras_nxt;
  logic [W-1:0] skip_r, skip_nxt;

  logic [W-1:0]   iv_ticks, iv_extras, s_skip, l_skip, eff_ticks;
  logic [W-1:0]   ticks_a, extras_a, skip_a, ticks_d, extras_d, skip_d;
  logic           restart, err, spawn, behind;
  logic [2*W-1:0] have, want;

  assign iv_ticks  = W'(cfg.interval_ticks);
  assign iv_extras = W'(cfg.interval_extras);
  assign s_skip    = W'(cfg.short_skip);
  assign l_skip    = W'(cfg.long_skip);
  // zero length counts as one
  assign eff_ticks = (iv_ticks == '0) ? W'(1) : iv_ticks;

  always_comb begin
    restart  = (ticks_r == '0);
    err      = restart && (extras_r != '0);
    ticks_a  = restart ? eff_ticks : ticks_r;
    extras_a = restart ? iv_extras : extras_r;
    skip_a   = restart ? '0 : skip_r;

    ticks_d  = ticks_a - W'(1);
    spawn    = (skip_a == '0) && (extras_a != '0);
    extras_d = spawn ? extras_a - W'(1) : extras_a;

    // rate check: remaining share against nominal share
    have   = (2*W)'(extras_d) * (2*W)'(eff_ticks);
    want   = (2*W)'(iv_extras) * (2*W)'(ticks_d);
    behind = (have < want);

    if (spawn) begin
      skip_d = (ticks_d != '0) ? (behind ? l_skip : s_skip) : skip_a;
    end else if (skip_a != '0) begin
      skip_d = skip_a - W'(1);
    end else begin
      skip_d = skip_a;
    end

    ticks_nxt  = ticks_r;
    extras_nxt = extras_r;
    skip_nxt   = skip_r;
    if (step && tick) begin
      ticks_nxt  = ticks_d;
      extras_nxt = extras_d;
      skip_nxt   = skip_d;
    end

    res.spawn_count      = '0;
    res.extra_spawned    = 1'b0;
    res.interval_restart = 1'b0;
    res.underspawn_error = 1'b0;
    if (tick) begin
      res.spawn_count      = {1'b0, cfg.base_per_tick} + frep_pkg::SPAWN_W'(spawn);
      res.extra_spawned    = spawn;
      res.interval_restart = restart;
      res.underspawn_error = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r  <= '0;
      extras_r <= '0;
      skip_r   <= '0;
    end else begin
      ticks_r  <= ticks_nxt;
      extras_r <= extras_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

### sv/fractional_rate_event_pacer_top.sv
// Fractional-rate event pacer. One input beat is one tick; every beat gives one
// result beat: base_per_tick events plus at most one extra, with the extras
// spread so that interval_extras of them fall in each interval_ticks ticks.
// After an extra a skip count is loaded: long_skip when the remaining extras
// lag the nominal rate, short_skip otherwise. A tick beat with tick_pulse low
// leaves the counters alone and returns an all-zero result. Rate: one beat per
// clock while out_ready stays high. A beat passes the input register, then the
// step logic and result register. The clock period is set by the combinational
// step path: counter restart and decrement, the two rate-check multipliers and
// the compare that reloads the skip count. Registers are to be written through
// the cfg_ port only while no beat is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "fractional_rate_event_pacer_top_defines.svh"

module fractional_rate_event_pacer_top #(
  parameter int INTERVAL_WIDTH = 16   // counter width, 4 to 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_tick_pulse,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [frep_pkg::SPAWN_W-1:0]      out_spawn_count,
  output logic                              out_extra_spawned,
  output logic                              out_interval_restart,
  output logic                              out_underspawn_error,
  // register writes
  input  logic                              cfg_wr_en,
  input  logic [frep_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frep_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  frep_pkg::cfg_t cfg;
  frep_pkg::res_t step_res;

  // input register
  logic s1_valid_r, s1_valid_nxt;
  logic s1_tick_r, s1_tick_nxt;
  logic s1_adv;

  // result register
  logic           out_valid_r, out_valid_nxt;
  frep_pkg::res_t out_res_r, out_res_nxt;

  frep_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  frep_core #(
    .INTERVAL_WIDTH (INTERVAL_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (s1_adv),
    .tick  (s1_tick_r),
    .res   (step_res)
  );

  // the held tick moves on whenever the result register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_tick_nxt  = s1_tick_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_tick_nxt  = in_tick_pulse;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = step_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    s1_tick_r <= s1_tick_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_spawn_count      = out_res_r.spawn_count;
  assign out_extra_spawned    = out_res_r.extra_spawned;
  assign out_interval_restart = out_res_r.interval_restart;
  assign out_underspawn_error = out_res_r.underspawn_error;

  // an error is only ever reported on a restart
  `FREP_ASSERT_NOW(a_err_on_restart, out_valid_r && out_res_r.underspawn_error, out_res_r.interval_restart, "underspawn error without restart")

  // an advancing tick always lands in the result register
  `FREP_ASSERT_NEXT(a_adv_loads_out, s1_adv, out_valid_r, "advanced beat lost")

  // an extra adds exactly one to the base count
  `FREP_ASSERT_NOW(a_extra_count, out_valid_r && out_res_r.extra_spawned, out_res_r.spawn_count == ({1'b0, cfg.base_per_tick} + 9'd1), "extra count mismatch")

endmodule
